@@ design/sdbs_pkg.sv @@
// Package with codes, widths and limits for the diagonal block scatter.
package sdbs_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_NEW_BLOCK = 2'd0,
		FUNC_NEXT_COL  = 2'd1,
		FUNC_NONZERO   = 2'd2,
		FUNC_FINISH    = 2'd3
	} func_t;

	// result kind codes
	typedef enum logic {
		KIND_POINTER = 1'b0,
		KIND_WRITE   = 1'b1
	} kind_t;

	localparam int DIM_W      = 11;
	localparam int COL_W      = 10;
	localparam int ROW_IDX_W  = 20;
	localparam int ROW_OFS_W  = 21;
	localparam int AREA_W     = 21;
	localparam int ADDR_W     = 33;
	localparam int VALUE_W    = 64;

	localparam int OUT_ADDR_BITS = 32;

	localparam logic [DIM_W-1:0]     MAX_BLOCK_DIM = 11'd1024;
	localparam logic [ROW_OFS_W-1:0] MAX_ROWS      = 21'd1048576;
	localparam logic [ADDR_W-1:0]    ADDR_TOP      = ADDR_W'(64'd1 << OUT_ADDR_BITS);

endpackage

@@ design/sdbs_in_if.sv @@
// Input channel: one stream item per beat.
interface sdbs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           func;
	logic [sdbs_pkg::DIM_W-1:0]           block_rows;
	logic [sdbs_pkg::DIM_W-1:0]           block_cols;
	logic [sdbs_pkg::ROW_IDX_W-1:0]       row_index;
	logic [sdbs_pkg::VALUE_W-1:0]         value_bits;

	modport source (output valid, func, block_rows, block_cols, row_index, value_bits,
		input ready);
	modport sink (input valid, func, block_rows, block_cols, row_index, value_bits,
		output ready);
endinterface

@@ design/sdbs_out_if.sv @@
// Output channel: one pointer or dense write per beat.
interface sdbs_out_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [sdbs_pkg::ADDR_W-1:0]    address;
	logic [sdbs_pkg::VALUE_W-1:0]   value_out;

	modport source (output valid, kind, address, value_out, input ready);
	modport sink (input valid, kind, address, value_out, output ready);
endinterface

@@ design/sparse_diagonal_block_scatter_top.sv @@
// Diagonal block scatter of a compressed-column sparse stream.
// One item per cycle unless result stalls; an item is registered in stage 1,
// its result in the output register, which drains while the next item is taken.
// Stage 1 registers the item; stage 2 does a compare and an add against running offsets.
// Block area (rows x cols) is multiplied when a block opens and kept in a register.
// Reset (arst_n low, asynchronous) clears all valids and offsets to an empty 0 x 0 block.
module sparse_diagonal_block_scatter_top (
	input logic         clk,
	input logic         arst_n,
	sdbs_in_if.sink     item,
	sdbs_out_if.source  result
);

	localparam int DIM_W     = sdbs_pkg::DIM_W;
	localparam int COL_W     = sdbs_pkg::COL_W;
	localparam int ROW_OFS_W = sdbs_pkg::ROW_OFS_W;
	localparam int AREA_W    = sdbs_pkg::AREA_W;
	localparam int ADDR_W    = sdbs_pkg::ADDR_W;
	localparam int VALUE_W   = sdbs_pkg::VALUE_W;

	// stage 1 input register
	logic                                valid_s1;
	sdbs_pkg::func_t                     func_s1;
	logic [DIM_W-1:0]                    rows_s1;
	logic [DIM_W-1:0]                    cols_s1;
	logic [sdbs_pkg::ROW_IDX_W-1:0]      row_s1;
	logic [VALUE_W-1:0]                  value_s1;

	// running block state
	logic [ROW_OFS_W-1:0] row_offset_q;
	logic [DIM_W-1:0]     cur_rows_q;
	logic [DIM_W-1:0]     cur_cols_q;
	logic [COL_W-1:0]     col_q;
	logic [AREA_W-1:0]    area_q;
	logic [ADDR_W-1:0]    dense_base_q;
	logic [ADDR_W-1:0]    col_addr_q;

	// output register
	logic                 out_valid_q;
	sdbs_pkg::kind_t      kind_q;
	logic [ADDR_W-1:0]    address_q;
	logic [VALUE_W-1:0]   value_q;

	logic                 go;
	logic [DIM_W-1:0]     rows_cl;
	logic [DIM_W-1:0]     cols_cl;
	logic [ROW_OFS_W-1:0] row_sum;
	logic [ROW_OFS_W-1:0] new_row_offset;
	logic [ADDR_W:0]      base_sum;
	logic [ADDR_W-1:0]    new_base;
	logic [ADDR_W-1:0]    pointer;
	logic [ROW_OFS_W-1:0] row_g;
	logic [ROW_OFS_W-1:0] row_end;
	logic [ROW_OFS_W-1:0] row_diff;
	logic                 row_hit;
	logic [ADDR_W:0]      wr_sum;
	logic                 wr_ok;
	logic                 col_step;
	logic                 has_result;

	assign go          = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready  = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			func_s1  <= sdbs_pkg::func_t'(item.func);
			rows_s1  <= item.block_rows;
			cols_s1  <= item.block_cols;
			row_s1   <= item.row_index;
			value_s1 <= item.value_bits;
		end
	end

	// clamp of new block dimensions
	assign rows_cl = (rows_s1 > sdbs_pkg::MAX_BLOCK_DIM) ? sdbs_pkg::MAX_BLOCK_DIM : rows_s1;
	assign cols_cl = (cols_s1 > sdbs_pkg::MAX_BLOCK_DIM) ? sdbs_pkg::MAX_BLOCK_DIM : cols_s1;

	// block close: saturating row offset and dense base, then the one-based pointer
	assign row_sum        = row_offset_q + ROW_OFS_W'(cur_rows_q);
	assign new_row_offset = (row_sum > sdbs_pkg::MAX_ROWS) ? sdbs_pkg::MAX_ROWS : row_sum;
	assign base_sum       = {1'b0, dense_base_q} + (ADDR_W+1)'(area_q);
	assign new_base       = (base_sum > {1'b0, sdbs_pkg::ADDR_TOP}) ?
		sdbs_pkg::ADDR_TOP : base_sum[ADDR_W-1:0];
	assign pointer        = (new_base == sdbs_pkg::ADDR_TOP) ?
		sdbs_pkg::ADDR_TOP : new_base + ADDR_W'(1);

	// nonzero: row range check and dense address
	assign row_g    = ROW_OFS_W'(row_s1);
	assign row_end  = row_offset_q + ROW_OFS_W'(cur_rows_q);
	assign row_hit  = (cur_cols_q != '0) && (row_g >= row_offset_q) && (row_g < row_end);
	assign row_diff = row_g - row_offset_q;
	assign wr_sum   = {1'b0, col_addr_q} + (ADDR_W+1)'(row_diff[DIM_W-1:0]);
	assign wr_ok    = row_hit && (wr_sum < {1'b0, sdbs_pkg::ADDR_TOP});

	// column advance stays inside the block
	assign col_step = (DIM_W'(col_q) + DIM_W'(1)) < cur_cols_q;

	always_comb begin
		case (func_s1)
			sdbs_pkg::FUNC_NEW_BLOCK: has_result = 1'b1;
			sdbs_pkg::FUNC_FINISH:    has_result = 1'b1;
			sdbs_pkg::FUNC_NONZERO:   has_result = wr_ok;
			default:                  has_result = 1'b0;
		endcase
	end

	// block state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_offset_q <= '0;
			cur_rows_q   <= '0;
			cur_cols_q   <= '0;
			col_q        <= '0;
			area_q       <= '0;
			dense_base_q <= '0;
			col_addr_q   <= '0;
		end else if (go) begin
			case (func_s1)
				sdbs_pkg::FUNC_NEW_BLOCK: begin
					row_offset_q <= new_row_offset;
					dense_base_q <= new_base;
					col_addr_q   <= new_base;
					cur_rows_q   <= rows_cl;
					cur_cols_q   <= cols_cl;
					col_q        <= '0;
					area_q       <= AREA_W'(rows_cl) * AREA_W'(cols_cl);
				end
				sdbs_pkg::FUNC_FINISH: begin
					row_offset_q <= new_row_offset;
					dense_base_q <= new_base;
					col_addr_q   <= new_base;
					cur_rows_q   <= '0;
					cur_cols_q   <= '0;
					col_q        <= '0;
					area_q       <= '0;
				end
				sdbs_pkg::FUNC_NEXT_COL: begin
					if (col_step) begin
						col_q      <= col_q + COL_W'(1);
						col_addr_q <= col_addr_q + ADDR_W'(cur_rows_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= has_result;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_result) begin
			if (func_s1 == sdbs_pkg::FUNC_NONZERO) begin
				kind_q    <= sdbs_pkg::KIND_WRITE;
				address_q <= wr_sum[ADDR_W-1:0];
				value_q   <= value_s1;
			end else begin
				kind_q    <= sdbs_pkg::KIND_POINTER;
				address_q <= pointer;
				value_q   <= '0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.kind      = kind_q;
	assign result.address   = address_q;
	assign result.value_out = value_q;

endmodule

@@ design/sdbs_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
module sdbs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_kind,
	input logic [sdbs_pkg::ADDR_W-1:0]   out_address,
	input logic [sdbs_pkg::VALUE_W-1:0]  out_value
);

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// pointer beats carry a zero value
	a_ptr_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == sdbs_pkg::KIND_POINTER) |-> (out_value == '0))
		else $error("pointer beat with nonzero value");

	// pointer is one-based and saturates at the address top
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == sdbs_pkg::KIND_POINTER) |->
		(out_address != '0) && (out_address <= sdbs_pkg::ADDR_TOP))
		else $error("pointer out of range");

	// dense writes never reach the address top
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == sdbs_pkg::KIND_WRITE) |->
		(out_address < sdbs_pkg::ADDR_TOP))
		else $error("dense write address out of range");

endmodule

bind sparse_diagonal_block_scatter_top sdbs_checker u_sdbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_kind    (result.kind),
	.out_address (result.address),
	.out_value   (result.value_out)
);
